// ----- hw/rtl/first_fit_allocator_with_compaction_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit allocator
// Shared property shapes, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_ALLOCATOR_WITH_COMPACTION_CORE_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_WITH_COMPACTION_CORE_MACROS_SVH

// same-cycle implication
`define FFAC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// next-cycle implication
`define FFAC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// ----- hw/rtl/ffac_pkg.sv -----
// ----------------------------------------------------------------------------
// ffac_pkg
// Codes, defaults and controller/datapath interface types of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffac_pkg;

   localparam int DEF_MAX_CELLS   = 128;
   localparam int DEF_MAX_HANDLES = 128;
   localparam logic [7:0] MEM_CELLS_RESET = 8'd100;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_DEFRAG = 2'd2;

   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_NULL      = 2'd1;
   localparam logic [1:0] ST_ILLEGAL   = 2'd2;

   typedef struct packed {
      logic latch;
      logic a_init;
      logic a_step;
      logic a_hit;
      logic a_write;
      logic mark_step;
      logic e_read;
      logic e_load;
      logic e_step;
      logic d_init;
      logic d_skip;
      logic d_own_read;
      logic d_blk_read;
      logic d_move;
      logic d_step;
      logic d_advance;
      logic d_commit;
      logic rsp_ok;
      logic rsp_null;
      logic rsp_ill;
   } ffac_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic alloc_ok;
      logic erase_ok;
      logic scan_end;
      logic scan_hit;
      logic mark_done;
      logic e_done;
      logic d_end;
      logic d_cell_used;
      logic d_owner_ok;
      logic d_start_match;
      logic d_fill_done;
   } ffac_sts_type;

endpackage
`default_nettype wire

// ----- hw/rtl/ffac_ram.sv -----
// ----------------------------------------------------------------------------
// ffac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ffac_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffac_ctrl
// Sequencer for allocate, erase and defragment over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module ffac_ctrl
   import ffac_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire ffac_sts_type sts,
   output ffac_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_A_CHK, S_A_SCAN, S_A_WRITE, S_A_MARK,
      S_E_CHK, S_E_LOAD, S_E_CLR,
      S_D_INIT, S_D_CHK, S_D_OWN, S_D_BLK, S_D_FILL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               unique case (sts.op)
                  OP_ALLOC:  state_in = S_A_CHK;
                  OP_ERASE:  state_in = S_E_CHK;
                  OP_DEFRAG: state_in = S_D_INIT;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_A_CHK: begin
            if (sts.alloc_ok) begin
               cmd.a_init = 1'b1;
               state_in   = S_A_SCAN;
            end else begin
               cmd.rsp_null = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_A_SCAN: begin
            if (sts.scan_end) begin
               cmd.rsp_null = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.scan_hit) begin
               cmd.a_hit = 1'b1;
               state_in  = S_A_WRITE;
            end else begin
               cmd.a_step = 1'b1;
            end
         end
         S_A_WRITE: begin
            cmd.a_write = 1'b1;
            state_in    = S_A_MARK;
         end
         S_A_MARK: begin
            if (sts.mark_done) begin
               cmd.rsp_ok = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         S_E_CHK: begin
            if (sts.erase_ok) begin
               cmd.e_read = 1'b1;
               state_in   = S_E_LOAD;
            end else begin
               cmd.rsp_ill = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_E_LOAD: begin
            cmd.e_load = 1'b1;
            state_in   = S_E_CLR;
         end
         S_E_CLR: begin
            if (sts.e_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.e_step = 1'b1;
            end
         end
         S_D_INIT: begin
            cmd.d_init = 1'b1;
            state_in   = S_D_CHK;
         end
         S_D_CHK: begin
            if (sts.d_end) begin
               cmd.d_commit = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.d_cell_used) begin
               cmd.d_own_read = 1'b1;
               state_in       = S_D_OWN;
            end else begin
               cmd.d_skip = 1'b1;
            end
         end
         S_D_OWN: begin
            if (sts.d_owner_ok) begin
               cmd.d_blk_read = 1'b1;
               state_in       = S_D_BLK;
            end else begin
               cmd.d_skip = 1'b1;
               state_in   = S_D_CHK;
            end
         end
         S_D_BLK: begin
            if (sts.d_start_match) begin
               cmd.d_move = 1'b1;
               state_in   = S_D_FILL;
            end else begin
               cmd.d_skip = 1'b1;
               state_in   = S_D_CHK;
            end
         end
         S_D_FILL: begin
            if (sts.d_fill_done) begin
               cmd.d_advance = 1'b1;
               state_in      = S_D_CHK;
            end else begin
               cmd.d_step = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// ----- hw/rtl/ffac_dpath.sv -----
// ----------------------------------------------------------------------------
// ffac_dpath
// Cell map, handle tables, walk counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_allocator_with_compaction_core_macros.svh"
module ffac_dpath
   import ffac_pkg::*;
#(
   parameter int MAX_CELLS   = DEF_MAX_CELLS,
   parameter int MAX_HANDLES = DEF_MAX_HANDLES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_operand,
   input  wire logic               csr_write,
   input  wire logic [7:0]         csr_data,
   input  wire ffac_cmd_type       cmd,
   output ffac_sts_type            sts,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [7:0]              rsp_handle
);

   localparam int CW  = $clog2(MAX_CELLS);
   localparam int NW  = CW + 1;
   localparam int HW  = $clog2(MAX_HANDLES);
   localparam int HNW = HW + 1;

   logic [7:0]         mem_cells_ff;
   logic signed [31:0] operand_ff;
   logic [HNW-1:0]     last_ff;
   logic [MAX_CELLS-1:0]   used_ff, fresh_ff;
   logic [MAX_HANDLES-1:0] live_ff;
   logic [NW-1:0]      i_ff, run_ff, run_in, w_ff, k_ff, end_ff, len_ff, start_ff;
   logic [HNW-1:0]     hndl_ff;
   logic [NW-1:0]      usable;
   logic [HW-1:0]      erase_idx, owner_idx;

   logic           own_we, tbl_we;
   logic [CW-1:0]  own_waddr, own_raddr;
   logic [HNW-1:0] own_wdata, own_rdata;
   logic [HW-1:0]  tbl_waddr, tbl_raddr;
   logic [CW-1:0]  bst_wdata, bst_rdata;
   logic [NW-1:0]  bln_wdata, bln_rdata;

   assign usable    = (32'(mem_cells_ff) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(mem_cells_ff);
   assign erase_idx = HW'(operand_ff - 32'sd1);
   assign owner_idx = HW'(own_rdata - HNW'(1));
   assign run_in    = used_ff[i_ff[CW-1:0]] ? '0 : run_ff + NW'(1);

   always_comb begin
      sts               = '0;
      sts.op            = req_opcode;
      sts.alloc_ok      = (operand_ff > 32'sd0) && (operand_ff <= $signed(32'(usable)))
                          && (32'(last_ff) < MAX_HANDLES);
      sts.erase_ok      = (operand_ff >= 32'sd1) && (operand_ff <= $signed(32'(last_ff)))
                          && live_ff[erase_idx];
      sts.scan_end      = (i_ff >= usable);
      sts.scan_hit      = (run_in == len_ff);
      sts.mark_done     = (k_ff >= end_ff);
      sts.e_done        = (k_ff >= end_ff);
      sts.d_end         = (32'(i_ff) >= MAX_CELLS);
      sts.d_cell_used   = used_ff[i_ff[CW-1:0]];
      sts.d_owner_ok    = (own_rdata >= HNW'(1)) && (own_rdata <= last_ff)
                          && (32'(own_rdata) <= MAX_HANDLES) && live_ff[owner_idx];
      sts.d_start_match = (NW'(bst_rdata) == i_ff);
      sts.d_fill_done   = (k_ff >= end_ff) || (32'(k_ff) >= MAX_CELLS);
   end

   // table port muxing: allocate and move write, erase and walk read
   always_comb begin
      own_we    = cmd.a_write | cmd.d_move;
      own_waddr = cmd.d_move ? w_ff[CW-1:0] : start_ff[CW-1:0];
      own_wdata = cmd.d_move ? hndl_ff : last_ff + HNW'(1);
      own_raddr = i_ff[CW-1:0];
      tbl_we    = cmd.a_write | cmd.d_move;
      tbl_waddr = cmd.d_move ? HW'(hndl_ff - HNW'(1)) : last_ff[HW-1:0];
      bst_wdata = cmd.d_move ? w_ff[CW-1:0] : start_ff[CW-1:0];
      // a moved block keeps its length
      bln_wdata = cmd.d_move ? bln_rdata : len_ff;
      tbl_raddr = cmd.e_read ? erase_idx : owner_idx;
   end

   ffac_ram #(.WIDTH(HNW), .DEPTH(MAX_CELLS)) u_owner (
      .clock(clock), .wr_en(own_we), .wr_addr(own_waddr), .wr_data(own_wdata),
      .rd_addr(own_raddr), .rd_data(own_rdata)
   );

   ffac_ram #(.WIDTH(CW), .DEPTH(MAX_HANDLES)) u_bstart (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(bst_wdata),
      .rd_addr(tbl_raddr), .rd_data(bst_rdata)
   );

   ffac_ram #(.WIDTH(NW), .DEPTH(MAX_HANDLES)) u_blen (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(bln_wdata),
      .rd_addr(tbl_raddr), .rd_data(bln_rdata)
   );

   // walk registers carry payload only
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         operand_ff <= req_operand;
         len_ff     <= NW'(req_operand);
      end
      if (cmd.a_init) begin
         i_ff   <= '0;
         run_ff <= '0;
      end
      if (cmd.a_step) begin
         i_ff   <= i_ff + NW'(1);
         run_ff <= run_in;
      end
      if (cmd.a_hit) begin
         start_ff <= i_ff + NW'(1) - len_ff;
         k_ff     <= i_ff + NW'(1) - len_ff;
         end_ff   <= i_ff + NW'(1);
      end
      if (cmd.mark_step || cmd.e_step || cmd.d_step) begin
         k_ff <= k_ff + NW'(1);
      end
      if (cmd.e_load) begin
         k_ff   <= NW'(bst_rdata);
         end_ff <= NW'(bst_rdata) + bln_rdata;
      end
      if (cmd.d_init) begin
         i_ff     <= '0;
         w_ff     <= '0;
         fresh_ff <= '0;
      end
      if (cmd.d_skip) begin
         i_ff <= i_ff + NW'(1);
      end
      if (cmd.d_blk_read) begin
         hndl_ff <= own_rdata;
      end
      if (cmd.d_move) begin
         len_ff <= bln_rdata;
         k_ff   <= w_ff;
         end_ff <= w_ff + bln_rdata;
      end
      if (cmd.d_step) begin
         fresh_ff[k_ff[CW-1:0]] <= 1'b1;
      end
      if (cmd.d_advance) begin
         w_ff <= end_ff;
         i_ff <= i_ff + len_ff;
      end
      if (cmd.rsp_ok || cmd.rsp_null || cmd.rsp_ill) begin
         rsp_status <= cmd.rsp_ok ? ST_ALLOCATED : (cmd.rsp_null ? ST_NULL : ST_ILLEGAL);
         rsp_handle <= cmd.rsp_ok ? 8'(last_ff) : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_cells_ff <= MEM_CELLS_RESET;
         last_ff      <= '0;
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_strobe   <= 1'b0;
      end else begin
         rsp_strobe <= cmd.rsp_ok | cmd.rsp_null | cmd.rsp_ill;
         if (csr_write) begin
            mem_cells_ff <= csr_data;
         end
         if (cmd.a_write) begin
            live_ff[last_ff[HW-1:0]] <= 1'b1;
            last_ff                  <= last_ff + HNW'(1);
         end
         if (cmd.mark_step) begin
            used_ff[k_ff[CW-1:0]] <= 1'b1;
         end
         if (cmd.e_load) begin
            live_ff[erase_idx] <= 1'b0;
         end
         if (cmd.e_step) begin
            used_ff[k_ff[CW-1:0]] <= 1'b0;
         end
         if (cmd.d_commit) begin
            used_ff <= fresh_ff;
         end
      end
   end

   `FFAC_ASSERT_NOW(a_one_rsp, 1'b1, $onehot0({cmd.rsp_ok, cmd.rsp_null, cmd.rsp_ill}))
   `FFAC_ASSERT_NOW(a_last_cap, 1'b1, 32'(last_ff) <= MAX_HANDLES)
   `FFAC_ASSERT_NEXT(a_fail_zero, cmd.rsp_null || cmd.rsp_ill, rsp_strobe && rsp_handle == 8'd0)
   `FFAC_ASSERT_NOW(a_mark_range, cmd.mark_step, k_ff < end_ff && k_ff < usable)

endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_allocator_with_compaction_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_core
// First-fit cell allocator with handle table, erase and order-keeping compaction.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_opcode, req_operand                 start & !busy
//  result    rsp_status, rsp_handle                  rsp_strobe, one cycle, no stall
//  config    csr_data                                csr_valid & csr_ready (always ready)
//
//  Allocate walks the usable cells one per cycle, then marks the run. Erase clears
//  the cells of its block. Defragment walks the whole store. Result is registered
//  and comes in the cycle after the sequencer ends; the next item may start then.
//  A successful erase gives no result.
//  Synchronous reset clears the cell map, live bits and handle counter at once.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_allocator_with_compaction_core
   import ffac_pkg::*;
#(
   parameter int MAX_CELLS   = DEF_MAX_CELLS,
   parameter int MAX_HANDLES = DEF_MAX_HANDLES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_operand,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_data,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [7:0]              rsp_handle
);

   ffac_cmd_type cmd;
   ffac_sts_type sts;

   assign csr_ready = 1'b1;

   ffac_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   ffac_dpath #(.MAX_CELLS(MAX_CELLS), .MAX_HANDLES(MAX_HANDLES)) u_dpath (
      .clock(clock), .reset(reset),
      .req_opcode(req_opcode), .req_operand(req_operand),
      .csr_write(csr_valid & csr_ready), .csr_data(csr_data),
      .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_handle(rsp_handle)
   );

endmodule
`default_nettype wire

// ----- sim/first_fit_allocator_with_compaction_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_core_tb
// Runs directed and random allocate, erase and defragment items against an
// in-bench model of the cell map and handle table, under several cell counts.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_core_tb;
   import ffac_pkg::*;

   localparam int NCELLS   = DEF_MAX_CELLS;
   localparam int NHANDLES = DEF_MAX_HANDLES;
   localparam int SETTLE   = 4;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] handle;
   } alloc_rsp_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_ALLOC;
   logic signed [31:0] req_operand = '0;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_data = '0;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_handle;

   // allocator image
   bit          map_used [NCELLS];
   int unsigned map_owner [NCELLS];
   int unsigned tbl_start [NHANDLES];
   int unsigned tbl_len [NHANDLES];
   bit          tbl_live [NHANDLES];
   int unsigned handles_issued;
   int unsigned cells_reg;

   alloc_rsp_t pending_rsp [$];
   int         fails = 0;

   first_fit_allocator_with_compaction_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_operand (req_operand),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_handle  (rsp_handle)
   );

   always #4 clock = ~clock;

   function automatic void model_alloc(longint len);
      alloc_rsp_t  r;
      int unsigned n, run, i, s;
      n = (cells_reg > NCELLS) ? NCELLS : cells_reg;
      r.status = ST_NULL;
      r.handle = '0;
      run = 0;
      if (len > 0 && len <= longint'(n) && handles_issued < NHANDLES) begin
         for (i = 0; i < n; i++) begin
            run = map_used[i] ? 0 : run + 1;
            if (run == len) break;
         end
         if (i < n) begin
            s = i + 1 - int'(len);
            handles_issued++;
            tbl_start[handles_issued-1] = s;
            tbl_len[handles_issued-1]   = int'(len);
            tbl_live[handles_issued-1]  = 1'b1;
            map_owner[s] = handles_issued;
            for (int k = s; k <= i; k++) map_used[k] = 1'b1;
            r.status = ST_ALLOCATED;
            r.handle = handles_issued[7:0];
         end
      end
      pending_rsp.push_back(r);
   endfunction

   function automatic void model_erase(longint h);
      alloc_rsp_t r;
      if (h < 1 || h > longint'(handles_issued) || !tbl_live[h-1]) begin
         r.status = ST_ILLEGAL;
         r.handle = '0;
         pending_rsp.push_back(r);
      end else begin
         for (int k = 0; k < tbl_len[h-1]; k++)
            if (tbl_start[h-1] + k < NCELLS) map_used[tbl_start[h-1] + k] = 1'b0;
         tbl_live[h-1] = 1'b0;
      end
   endfunction

   function automatic void model_compact();
      bit          packed_map [NCELLS];
      int unsigned i, w, h, l;
      i = 0;
      w = 0;
      for (int k = 0; k < NCELLS; k++) packed_map[k] = 1'b0;
      while (i < NCELLS) begin
         h = map_owner[i];
         if (!map_used[i] || h < 1 || h > handles_issued || h > NHANDLES ||
             !tbl_live[h-1] || tbl_start[h-1] != i) begin
            i++;
         end else begin
            l = tbl_len[h-1];
            tbl_start[h-1] = w;
            map_owner[w] = h;
            for (int k = 0; k < l && w + k < NCELLS; k++) packed_map[w+k] = 1'b1;
            w += l;
            i += (l != 0) ? l : 1;
         end
      end
      map_used = packed_map;
   endfunction

   // send one item; start stays high when the next item follows at once
   task automatic send_item(logic [1:0] op, logic [31:0] arg);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         @(negedge clock) start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       = 1'b1;
      req_opcode  = op;
      req_operand = arg;
      do @(posedge clock); while (busy);
      case (op)
         OP_ALLOC:  model_alloc(longint'($signed(arg)));
         OP_ERASE:  model_erase(longint'($signed(arg)));
         OP_DEFRAG: model_compact();
         default: ;
      endcase
   endtask

   // drain all results and let the last item finish
   task automatic wait_quiet();
      @(negedge clock) start = 1'b0;
      while (busy || pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_cells(logic [7:0] v);
      wait_quiet();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      cells_reg = v;
      @(negedge clock) csr_valid = 1'b0;
   endtask

   task automatic test_directed();
      write_cells(8'd100);
      send_item(OP_ALLOC, 32'd0);
      send_item(OP_ALLOC, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'h8000_0000);
      send_item(OP_ALLOC, 32'h7FFF_FFFF);
      send_item(OP_ALLOC, 32'd101);
      send_item(OP_ALLOC, 32'd1);
      send_item(OP_ALLOC, 32'd100);
      send_item(OP_ALLOC, 32'd99);
      send_item(OP_ERASE, 32'd0);
      send_item(OP_ERASE, 32'hFFFF_FFFF);
      send_item(OP_ERASE, 32'h8000_0000);
      send_item(OP_ERASE, 32'd200);
      send_item(OP_ERASE, 32'd1);
      send_item(OP_ERASE, 32'd1);
      send_item(OP_ALLOC, 32'd3);
      send_item(OP_DEFRAG, 32'hA5A5_5A5A);
      send_item(2'd3, 32'd5);
      send_item(OP_ALLOC, 32'd1);
      send_item(OP_ERASE, 32'd2);
      send_item(OP_DEFRAG, 32'd0);
      send_item(OP_ALLOC, 32'd4);
   endtask

   task automatic test_cell_extremes();
      write_cells(8'd0);
      send_item(OP_ALLOC, 32'd1);
      send_item(OP_DEFRAG, 32'd0);
      write_cells(8'd255);
      send_item(OP_ALLOC, 32'd129);
      send_item(OP_ALLOC, 32'd20);
      write_cells(8'd1);
      send_item(OP_ALLOC, 32'd1);
      send_item(OP_DEFRAG, 32'd0);
   endtask

   task automatic test_random(int count, logic [7:0] cells);
      int          sent, pick;
      logic [31:0] arg;
      write_cells(cells);
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 9))
               0:       arg = $urandom();
               1:       arg = $urandom_range(0, 255);
               2:       arg = $urandom_range(9, 128);
               default: arg = $urandom_range(1, 8);
            endcase
            send_item(OP_ALLOC, arg);
            sent++;
         end else if (pick < 82) begin
            arg = $urandom();
            if (handles_issued > 0 && $urandom_range(0, 9) < 8) begin
               // prefer a live handle
               for (int t = 0; t < 6; t++) begin
                  arg = $urandom_range(1, handles_issued);
                  if (tbl_live[arg-1]) break;
               end
            end
            send_item(OP_ERASE, arg);
            sent++;
         end else if (pick < 96) begin
            send_item(OP_DEFRAG, $urandom());
            sent++;
         end else begin
            send_item(2'd3, $urandom());
         end
      end
   endtask

   always @(posedge clock) begin
      alloc_rsp_t exp_r;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: status %0d handle %0d", rsp_status, rsp_handle);
            fails++;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
               fails++;
            end
            if (rsp_handle !== exp_r.handle) begin
               $error("handle: expected %0d, actual %0d", exp_r.handle, rsp_handle);
               fails++;
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < NCELLS; k++) begin
         map_used[k]  = 1'b0;
         map_owner[k] = 0;
      end
      for (int k = 0; k < NHANDLES; k++) begin
         tbl_start[k] = 0;
         tbl_len[k]   = 0;
         tbl_live[k]  = 1'b0;
      end
      handles_issued = 0;
      cells_reg      = MEM_CELLS_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      test_directed();
      test_random(350, 8'd16);
      test_random(350, 8'd100);
      test_cell_extremes();
      test_random(350, 8'd128);
      test_random(300, 8'd255);
      test_random(300, 8'd40);
      test_random(150, 8'd1);
      test_random(150, 8'($urandom_range(2, 127)));
      wait_quiet();
      if (fails == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule
